/* hdl/pbfw_pkg.sv */
// Shared types and constants for the page buffer tag controller.
`timescale 1ns / 1ps
`default_nettype none

package pbfw_pkg;

    localparam int FRAMES_DEFAULT = 16;
    localparam int PAGE_W         = 16;
    localparam int SLOT_OUT_W     = 4;
    localparam int CNT_OUT_W      = 32;
    localparam int FIU_W          = 5;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 152;
    localparam int CFG_DATA_W     = 16;

    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ACCESS      = 2'd0,
        OP_MARK        = 2'd1,
        OP_FLUSH       = 2'd2,
        OP_FLUSH_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_HIT  = 3'd0,
        KIND_LOAD = 3'd1,
        KIND_WB   = 3'd2,
        KIND_ERR  = 3'd3,
        KIND_DONE = 3'd4
    } kind_t;

    typedef enum logic [0:0] {
        REG_FRAMES_IN_USE = 1'b0,
        REG_PAGE_COUNT    = 1'b1
    } cfg_reg_t;

    // where the page and slot of a result come from
    typedef enum logic [2:0] {
        SRC_ZERO       = 3'd0,
        SRC_PAGE       = 3'd1,
        SRC_MATCH      = 3'd2,
        SRC_VICTIM_TAG = 3'd3,
        SRC_VICTIM_NEW = 3'd4,
        SRC_FLUSH      = 3'd5
    } src_t;

    typedef struct packed {
        logic  capture;
        logic  emit;
        kind_t kind;
        logic  last;
        src_t  src;
        logic  bump_hit;
        logic  bump_miss;
        logic  bump_load;
        logic  bump_wb;
        logic  set_dirty;
        logic  install;
        logic  clean_flush;
        logic  clear_all;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic hit;
        logic victim_dirty;
        logic flush_any;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/pbfw_datapath.sv */
// Datapath: tag store, valid/dirty bits, FIFO pointers, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module pbfw_datapath import pbfw_pkg::*; #(
    parameter int FRAMES = FRAMES_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tready,
    input  wire dp_cmd_t               dp_cmd,
    output dp_status_t                 dp_status,
    output logic                       m_tvalid,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [2:0]                 m_tuser,
    output logic                       m_tlast
);

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int CMP_W  = (CNT_W > FIU_W) ? CNT_W : FIU_W;

    function automatic logic [CNT_OUT_W-1:0] sat_inc(input logic [CNT_OUT_W-1:0] v,
                                                     input logic en);
        logic [CNT_OUT_W-1:0] r;
        r = v;
        if (en && (v != {CNT_OUT_W{1'b1}})) begin
            r = v + CNT_OUT_W'(1);
        end
        return r;
    endfunction

    // configuration
    logic [FIU_W-1:0]  fiu_reg;
    logic [PAGE_W-1:0] page_count_reg;

    // captured item
    op_t               op_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [FRAMES-1:0] match_reg;
    logic [FRAMES-1:0] match_next;

    // slot state
    logic [PAGE_W-1:0] tag_reg [FRAMES];
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FRAMES-1:0] dirty_reg, dirty_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [SLOT_W-1:0] oldest_reg;

    // statistics
    logic [CNT_OUT_W-1:0] hits_reg, misses_reg, loads_reg, wbs_reg;

    // result register
    logic                  m_valid_reg;
    kind_t                 kind_reg;
    logic                  last_reg;
    logic [PAGE_W-1:0]     out_page_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;

    logic [CMP_W-1:0]  fiu_ext, cap, fill_ext, oldest_ext, step_ext;
    logic              full;
    logic [SLOT_W-1:0] victim, oldest_next, hit_slot, flush_idx, rd_idx;
    logic [FRAMES-1:0] pend, flush_low;
    logic [PAGE_W-1:0] rd_tag, sel_page;
    logic [SLOT_W-1:0] sel_slot;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    // tag compare against the incoming page, registered for the next cycle
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match_next[i] = valid_reg[i] && (tag_reg[i] == s_tdata[PAGE_W-1:0]);
        end
    end

    always_comb begin
        hit_slot = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (match_reg[i]) begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    // lowest dirty slot for flush walks
    assign pend      = valid_reg & dirty_reg;
    assign flush_low = pend & (~pend + FRAMES'(1));

    always_comb begin
        flush_idx = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (flush_low[i]) begin
                flush_idx = flush_idx | SLOT_W'(i);
            end
        end
    end

    // effective capacity and victim choice
    always_comb begin
        fiu_ext    = CMP_W'(fiu_reg);
        fill_ext   = CMP_W'(fill_reg);
        oldest_ext = CMP_W'(oldest_reg);
        if (fiu_ext == '0) begin
            cap = CMP_W'(1);
        end else if (fiu_ext > CMP_W'(FRAMES)) begin
            cap = CMP_W'(FRAMES);
        end else begin
            cap = fiu_ext;
        end
        full = (fill_ext >= cap);
        if (full) begin
            victim = (oldest_ext >= fill_ext) ? '0 : oldest_reg;
        end else begin
            victim = fill_reg[SLOT_W-1:0];
        end
        step_ext    = CMP_W'(victim) + CMP_W'(1);
        oldest_next = (step_ext >= fill_ext) ? '0 : step_ext[SLOT_W-1:0];
    end

    assign rd_idx = (dp_cmd.src == SRC_FLUSH) ? flush_idx : victim;
    assign rd_tag = tag_reg[rd_idx];

    always_comb begin
        sel_page = '0;
        sel_slot = '0;
        case (dp_cmd.src)
            SRC_ZERO: begin
            end
            SRC_PAGE: begin
                sel_page = page_reg;
            end
            SRC_MATCH: begin
                sel_page = page_reg;
                sel_slot = hit_slot;
            end
            SRC_VICTIM_TAG: begin
                sel_page = rd_tag;
                sel_slot = victim;
            end
            SRC_VICTIM_NEW: begin
                sel_page = page_reg;
                sel_slot = victim;
            end
            SRC_FLUSH: begin
                sel_page = rd_tag;
                sel_slot = flush_idx;
            end
            default: begin
            end
        endcase
    end

    assign slot_ext = {{SLOT_OUT_W{1'b0}}, sel_slot};

    always_comb begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        if (dp_cmd.set_dirty) begin
            dirty_next = dirty_next | match_reg;
        end
        if (dp_cmd.clean_flush) begin
            dirty_next = dirty_next & ~flush_low;
        end
        if (dp_cmd.install) begin
            valid_next[victim] = 1'b1;
            dirty_next[victim] = 1'b0;
        end
        if (dp_cmd.clear_all) begin
            valid_next = '0;
            dirty_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg        <= FIU_RESET;
            page_count_reg <= '0;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            loads_reg      <= '0;
            wbs_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FRAMES_IN_USE: fiu_reg        <= cfg_data[FIU_W-1:0];
                    REG_PAGE_COUNT:    page_count_reg <= cfg_data[PAGE_W-1:0];
                    default: begin
                    end
                endcase
            end
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            hits_reg   <= sat_inc(hits_reg, dp_cmd.bump_hit);
            misses_reg <= sat_inc(misses_reg, dp_cmd.bump_miss);
            loads_reg  <= sat_inc(loads_reg, dp_cmd.bump_load);
            wbs_reg    <= sat_inc(wbs_reg, dp_cmd.bump_wb);
            if (dp_cmd.install) begin
                if (full) begin
                    oldest_reg <= oldest_next;
                end else begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            if (dp_cmd.clear_all) begin
                fill_reg   <= '0;
                oldest_reg <= '0;
            end
            if (dp_cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            op_reg    <= op_t'(s_tuser);
            page_reg  <= s_tdata[PAGE_W-1:0];
            match_reg <= match_next;
        end
        if (dp_cmd.install) begin
            tag_reg[victim] <= page_reg;
        end
        if (dp_cmd.emit) begin
            kind_reg     <= dp_cmd.kind;
            last_reg     <= dp_cmd.last;
            out_page_reg <= sel_page;
            out_slot_reg <= slot_ext[SLOT_OUT_W-1:0];
        end
    end

    assign dp_status.op           = op_reg;
    assign dp_status.err          = (page_reg >= page_count_reg);
    assign dp_status.hit          = |match_reg;
    assign dp_status.victim_dirty = full && dirty_reg[victim];
    assign dp_status.flush_any    = |pend;
    assign dp_status.out_free     = !m_valid_reg || m_tready;

    // counters always show the values as of the latest result
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, wbs_reg, loads_reg, misses_reg, hits_reg,
                       out_slot_reg, out_page_reg};

endmodule

`default_nettype wire

/* hdl/pbfw_ctrl.sv */
// Controller: sequences each command into result transfers.
`timescale 1ns / 1ps
`default_nettype none

module pbfw_ctrl import pbfw_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t dp_status,
    output dp_cmd_t         dp_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_LOAD   = 4'b0100,
        ST_FLUSH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (dp_status.op)
                    OP_ACCESS: begin
                        if (dp_status.out_free) begin
                            dp_cmd.emit = 1'b1;
                            state_next  = ST_IDLE;
                            if (dp_status.err) begin
                                dp_cmd.kind = KIND_ERR;
                                dp_cmd.src  = SRC_PAGE;
                                dp_cmd.last = 1'b1;
                            end else if (dp_status.hit) begin
                                dp_cmd.kind     = KIND_HIT;
                                dp_cmd.src      = SRC_MATCH;
                                dp_cmd.last     = 1'b1;
                                dp_cmd.bump_hit = 1'b1;
                            end else if (dp_status.victim_dirty) begin
                                // dirty victim: write-back goes out first
                                dp_cmd.kind      = KIND_WB;
                                dp_cmd.src       = SRC_VICTIM_TAG;
                                dp_cmd.bump_miss = 1'b1;
                                dp_cmd.bump_wb   = 1'b1;
                                state_next       = ST_LOAD;
                            end else begin
                                dp_cmd.kind      = KIND_LOAD;
                                dp_cmd.src       = SRC_VICTIM_NEW;
                                dp_cmd.last      = 1'b1;
                                dp_cmd.bump_miss = 1'b1;
                                dp_cmd.bump_load = 1'b1;
                                dp_cmd.install   = 1'b1;
                            end
                        end
                    end
                    OP_MARK: begin
                        if (dp_status.out_free) begin
                            dp_cmd.emit      = 1'b1;
                            dp_cmd.kind      = KIND_DONE;
                            dp_cmd.src       = SRC_MATCH;
                            dp_cmd.last      = 1'b1;
                            dp_cmd.set_dirty = 1'b1;
                            state_next       = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_FLUSH;
                    end
                endcase
            end
            ST_LOAD: begin
                if (dp_status.out_free) begin
                    dp_cmd.emit      = 1'b1;
                    dp_cmd.kind      = KIND_LOAD;
                    dp_cmd.src       = SRC_VICTIM_NEW;
                    dp_cmd.last      = 1'b1;
                    dp_cmd.bump_load = 1'b1;
                    dp_cmd.install   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (dp_status.out_free) begin
                    dp_cmd.emit = 1'b1;
                    if (dp_status.flush_any) begin
                        dp_cmd.kind        = KIND_WB;
                        dp_cmd.src         = SRC_FLUSH;
                        dp_cmd.bump_wb     = 1'b1;
                        dp_cmd.clean_flush = 1'b1;
                    end else begin
                        dp_cmd.kind      = KIND_DONE;
                        dp_cmd.src       = SRC_ZERO;
                        dp_cmd.last      = 1'b1;
                        dp_cmd.clear_all = (dp_status.op == OP_FLUSH_CLEAR);
                        state_next       = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/page_buffer_fifo_writeback.sv */
// Top level of the buffer-pool tag controller with FIFO replacement and write-back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: page_id
//  m_       | out       | m_tvalid/m_tready  | m_tuser: kind; m_tlast: last; m_tdata: page, slot, stats
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index: register; cfg_data: value
//
// Flow: one command at a time. The accept cycle latches the item and registers the compare
// of the page against every tag in parallel; the decide state then issues the result once
// the output register is free. A miss with a dirty victim issues a write-back, then a load;
// a flush issues one write-back per dirty slot, then a done transfer (the flush walk issues
// one write-back transfer per cycle from the output register while m_tready keeps it free).
// Reset clears valid/dirty bits, pointers and counters; no clearing pass. Stalls: a result held
// in the output register blocks only the next result, not the accept of the next command.
`timescale 1ns / 1ps
`default_nettype none

module page_buffer_fifo_writeback import pbfw_pkg::*; #(
    parameter int FRAMES = FRAMES_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // command input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] page_id
    input  wire logic [1:0]            s_tuser,   // [1:0] cmd
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [15:0] result_page, [19:16] slot,
                                                  // [51:20] hits, [83:52] misses,
                                                  // [115:84] loads, [147:116] writebacks
    output logic [2:0]                 m_tuser,   // [2:0] kind
    output logic                       m_tlast,
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // registers are always writable; the host must write only while no command is in flight (not enforced here)
    assign cfg_ready = 1'b1;

    pbfw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    pbfw_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a new result is only loaded once the held one is gone
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // a hit always ends its command
    a_hit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_HIT)) |-> m_tlast)
        else $error("hit transfer without tlast");

    // a write-back is never the last transfer of its command
    a_wb_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_WB)) |-> !m_tlast)
        else $error("write-back transfer marked last");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command accepted back to back");

endmodule

`default_nettype wire
